>>> rtl/itbc_pkg.sv
package itbc_pkg;

  // Vertex store geometry
  localparam int unsigned VERTEX_DEPTH = 1024;
  localparam int unsigned VTX_AW       = $clog2(VERTEX_DEPTH);

  // Index compare width: holds any 16-bit index and a depth up to 65536
  localparam int unsigned CMP_W = 17;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(VERTEX_DEPTH);

  // Field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned PART_W   = DIFF_W + HALF_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned KEPT_W   = 16;
  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 176;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_CULL_DIR  = 2'd0;
  localparam cfg_idx_t CFG_TEX_PARTS = 2'd1;
  localparam cfg_idx_t CFG_VTX_LIMIT = 2'd2;
  localparam cfg_idx_t CFG_STRICT    = 2'd3;

  // Commands carried in tuser
  localparam logic CMD_WRITE_VTX = 1'b0;
  localparam logic CMD_TRIANGLE  = 1'b1;

  localparam logic [1:0] TEX_PARTS_UVW = 2'd3;
  localparam logic [1:0] CORNER_LAST   = 2'd2;
  localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

  typedef logic [VTX_AW-1:0] vtx_addr_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] u;
  } tex_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EDGE,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_CMP,
    S_EMIT
  } state_e;

endpackage

>>> rtl/itbc_ram.sv
module itbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port: optional write plus a registered read of the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/indexed_triangle_backface_cull.sv
// Channel   | Signals                         | Contents
// ----------+---------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata tuser       | vertex write or triangle command
// m_axis    | tvalid tready tdata tuser tlast | one corner of a kept triangle
// cfg       | cfg_we_i cfg_index_i cfg_data_i | cull direction, texture parts, limit, strict
//
// A vertex write is stored as it is accepted; a triangle with a bad index is dropped on acceptance.
// A triangle makes three reads through the single position/texture port, runs the edge, difference,
// multiply and sum steps of the split cross-product math and one compare, and, when kept, then makes
// three corner transfers; a culled triangle skips them. Stalls on m_axis hold the corner.
// Reset clears control state and the kept counter; the vertex store is not cleared.
// One item is in flight at a time, so store accesses never overlap.
module indexed_triangle_backface_cull (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] slot, [41:10] pos_x, [73:42] pos_y, [105:74] tex_u, [137:106] tex_v,
  // [169:138] tex_w, [185:170] corner_a, [201:186] corner_b, [217:202] corner_c
  input  logic [itbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_u, [127:96] out_v, [159:128] out_w,
  // [175:160] kept_total
  output logic [itbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] corner_number
  output logic [1:0]                          m_axis_tuser,
  // last_corner
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  itbc_pkg::cfg_idx_t                  cfg_index_i,
  input  itbc_pkg::cfg_data_t                 cfg_data_i
);

  import itbc_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [1:0] cull_dir_q;
  logic [1:0]        tex_parts_q;
  logic [10:0]       vtx_limit_q;
  logic              strict_q;

  // Input field split
  logic [SLOT_W-1:0]         in_slot;
  pos_t                      in_pos;
  tex_t                      in_tex;
  logic [INDEX_W-1:0]        in_corner [3];

  assign in_slot      = s_axis_tdata[9:0];
  assign in_pos.x     = s_axis_tdata[41:10];
  assign in_pos.y     = s_axis_tdata[73:42];
  assign in_tex.u     = s_axis_tdata[105:74];
  assign in_tex.v     = s_axis_tdata[137:106];
  assign in_tex.w     = s_axis_tdata[169:138];
  assign in_corner[0] = s_axis_tdata[185:170];
  assign in_corner[1] = s_axis_tdata[201:186];
  assign in_corner[2] = s_axis_tdata[217:202];

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Index bound: vertex limit clamped to the store depth
  logic [CMP_W-1:0] limit_cmp;
  logic [CMP_W-1:0] slot_cmp;
  logic [2:0]       idx_ok;
  logic             slot_ok;

  always_comb begin
    limit_cmp = (CMP_W'(vtx_limit_q) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(vtx_limit_q);
    slot_cmp  = CMP_W'(in_slot);
    slot_ok   = slot_cmp < DEPTH_CMP;
    for (int k = 0; k < 3; k++) begin
      idx_ok[k] = !in_corner[k][INDEX_W-1] && (CMP_W'(in_corner[k]) < limit_cmp);
    end
  end

  logic tri_start;
  logic vtx_write;
  assign tri_start = in_xfer && (s_axis_tuser == CMD_TRIANGLE) && (&idx_ok);
  assign vtx_write = in_xfer && (s_axis_tuser == CMD_WRITE_VTX) && slot_ok;

  // Corner indexes and read sequencing
  vtx_addr_t  idx_q [3];
  logic [1:0] rd_cnt_q;
  logic       rd_valid_q;
  logic [1:0] rd_sel_q;

  always_ff @(posedge clk_i) begin
    if (tri_start) begin
      for (int k = 0; k < 3; k++) begin
        idx_q[k] <= in_corner[k][VTX_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_sel_q   <= '0;
    end else begin
      rd_valid_q <= (state_q == S_READ);
      rd_sel_q   <= rd_cnt_q;
      rd_cnt_q   <= (state_q == S_READ) ? rd_cnt_q + 2'd1 : 2'd0;
    end
  end

  // Vertex store: write in the accept cycle, read one corner per cycle
  vtx_addr_t ram_addr;
  pos_t      pos_rdata;
  tex_t      tex_rdata;

  assign ram_addr = (state_q == S_READ) ? idx_q[rd_cnt_q] : slot_cmp[VTX_AW-1:0];

  itbc_ram #(
    .WIDTH ($bits(pos_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_write),
    .addr_i  (ram_addr),
    .wdata_i (in_pos),
    .rdata_o (pos_rdata)
  );

  itbc_ram #(
    .WIDTH ($bits(tex_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_write),
    .addr_i  (ram_addr),
    .wdata_i (in_tex),
    .rdata_o (tex_rdata)
  );

  // Hold the three corners as they return
  pos_t corner_pos_q [3];
  tex_t corner_tex_q [3];

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      corner_pos_q[rd_sel_q] <= pos_rdata;
      corner_tex_q[rd_sel_q] <= tex_rdata;
    end
  end

  // Edge vectors relative to the first corner
  logic signed [DIFF_W-1:0] ex1_q, ey1_q, ex2_q, ey2_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIFF) begin
      ex1_q <= DIFF_W'(corner_pos_q[1].x) - DIFF_W'(corner_pos_q[0].x);
      ey1_q <= DIFF_W'(corner_pos_q[1].y) - DIFF_W'(corner_pos_q[0].y);
      ex2_q <= DIFF_W'(corner_pos_q[2].x) - DIFF_W'(corner_pos_q[0].x);
      ey2_q <= DIFF_W'(corner_pos_q[2].y) - DIFF_W'(corner_pos_q[0].y);
    end
  end

  // Partial products: split the right operand into a signed high and unsigned low half
  logic signed [PART_W-1:0] p1_hi_q, p1_lo_q, p2_hi_q, p2_lo_q;
  logic signed [HALF_W+1:0] ey2_lo_s, ex2_lo_s;
  logic signed [DIFF_W-HALF_W-1:0] ey2_hi_s, ex2_hi_s;

  assign ey2_lo_s = {2'b00, ey2_q[HALF_W-1:0]};
  assign ex2_lo_s = {2'b00, ex2_q[HALF_W-1:0]};
  assign ey2_hi_s = ey2_q[DIFF_W-1:HALF_W];
  assign ex2_hi_s = ex2_q[DIFF_W-1:HALF_W];

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      p1_hi_q <= PART_W'(ex1_q * ey2_hi_s);
      p1_lo_q <= PART_W'(ex1_q * ey2_lo_s);
      p2_hi_q <= PART_W'(ey1_q * ex2_hi_s);
      p2_lo_q <= PART_W'(ey1_q * ex2_lo_s);
    end
  end

  // Recombine both full products
  logic signed [PROD_W-1:0] prod1_q, prod2_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      prod1_q <= (PROD_W'(p1_hi_q) <<< HALF_W) + PROD_W'(p1_lo_q);
      prod2_q <= (PROD_W'(p2_hi_q) <<< HALF_W) + PROD_W'(p2_lo_q);
    end
  end

  // Area test: the cross product is prod1 - prod2
  logic area_gt, area_eq, pos_ok, neg_ok, keep;

  always_comb begin
    area_gt = prod1_q > prod2_q;
    area_eq = prod1_q == prod2_q;
    pos_ok  = strict_q ? area_gt : (area_gt || area_eq);
    neg_ok  = strict_q ? (!area_gt && !area_eq) : !area_gt;
    keep    = (cull_dir_q == 2'sd0) || (cull_dir_q[1] ? neg_ok : pos_ok);
  end

  // Kept-triangle counter, saturating
  logic [KEPT_W-1:0] kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
    end else if ((state_q == S_CMP) && keep && (kept_q != KEPT_MAX)) begin
      kept_q <= kept_q + KEPT_W'(1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_dir_q  <= '0;
      tex_parts_q <= '0;
      vtx_limit_q <= '0;
      strict_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CULL_DIR:  cull_dir_q  <= cfg_data_i[1:0];
        CFG_TEX_PARTS: tex_parts_q <= cfg_data_i[1:0];
        CFG_VTX_LIMIT: vtx_limit_q <= cfg_data_i;
        CFG_STRICT:    strict_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // Corner emission
  logic [1:0] corner_q;
  logic       out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
    end else if (state_q != S_EMIT) begin
      corner_q <= '0;
    end else if (out_xfer) begin
      corner_q <= corner_q + 2'd1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (tri_start) state_d = S_READ;
      S_READ: if (rd_cnt_q == 2'd2) state_d = S_EDGE;
      S_EDGE: state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_CMP;
      S_CMP:  state_d = keep ? S_EMIT : S_IDLE;
      S_EMIT: if (out_xfer && (corner_q == CORNER_LAST)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  pos_t out_pos;
  tex_t out_tex;

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_EMIT);
    out_pos       = corner_pos_q[corner_q];
    out_tex       = corner_tex_q[corner_q];
    if (!tex_parts_q[1]) begin
      out_tex.u = '0;
      out_tex.v = '0;
    end
    if (tex_parts_q != TEX_PARTS_UVW) begin
      out_tex.w = '0;
    end
    m_axis_tdata = {kept_q, out_tex.w, out_tex.v, out_tex.u, out_pos.y, out_pos.x};
    m_axis_tuser = corner_q;
    m_axis_tlast = (corner_q == CORNER_LAST);
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a corner is pending");

  a_kept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(kept_q) |-> ($past(state_q) == S_CMP))
    else $error("kept counter moved outside the area decision");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast) |=> (state_q == S_IDLE))
    else $error("block not idle after the last corner");

  a_first_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (corner_q == 2'd0))
    else $error("emission did not start at the first corner");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |-> !rd_valid_q)
    else $error("edge math started before all corners returned");
`endif

endmodule

>>> test/tb.sv
module tb;
  import itbc_pkg::*;

  // Cull direction register encodings (two-bit signed)
  localparam logic [1:0] DIR_KEEP_ALL = 2'b00;
  localparam logic [1:0] DIR_POS      = 2'b01;
  localparam logic [1:0] DIR_NEG      = 2'b11;
  localparam logic [1:0] DIR_NEG_WIDE = 2'b10;

  // Texture part counts below the full set
  localparam logic [1:0] TEX_NONE = 2'd0;
  localparam logic [1:0] TEX_ONE  = 2'd1;
  localparam logic [1:0] TEX_UV   = 2'd2;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN   = 32'h8000_0000;
  localparam logic [31:0] Q_M_ONE = 32'hFFFF_FFFF;

  // Quiet cycles after the last corner before the block counts as idle
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       u;
    logic [31:0]       v;
    logic [31:0]       w;
    logic [1:0]        num;
    logic              last;
    logic [KEPT_W-1:0] kept;
  } corner_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = CMD_WRITE_VTX;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  cfg_idx_t               cfg_index_i = CFG_CULL_DIR;
  cfg_data_t              cfg_data_i = '0;

  // Vertex store mirror and settings of the culling predictor
  logic [31:0]       vtx_x [VERTEX_DEPTH];
  logic [31:0]       vtx_y [VERTEX_DEPTH];
  logic [31:0]       vtx_u [VERTEX_DEPTH];
  logic [31:0]       vtx_v [VERTEX_DEPTH];
  logic [31:0]       vtx_w [VERTEX_DEPTH];
  bit                vtx_written [VERTEX_DEPTH];
  int                written_slots[$];
  logic [KEPT_W-1:0] kept_count = '0;
  logic [1:0]        cull_dir = DIR_KEEP_ALL;
  logic [1:0]        tex_parts = TEX_NONE;
  logic [10:0]       vtx_limit = '0;
  logic              strict_mode = 1'b0;

  corner_t pending_corners[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  always #4 clk_i = ~clk_i;

  indexed_triangle_backface_cull u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Sign of the edge cross product, formed exactly at full width
  function automatic int winding_sign(input int i0, input int i1, input int i2);
    logic signed [32:0] ex1, ey1, ex2, ey2;
    logic signed [65:0] p1, p2;
    logic signed [66:0] wedge;
    ex1 = $signed(vtx_x[i1]) - $signed(vtx_x[i0]);
    ey1 = $signed(vtx_y[i1]) - $signed(vtx_y[i0]);
    ex2 = $signed(vtx_x[i2]) - $signed(vtx_x[i0]);
    ey2 = $signed(vtx_y[i2]) - $signed(vtx_y[i0]);
    p1 = ex1 * ey2;
    p2 = ey1 * ex2;
    wedge = p1 - p2;
    if (wedge < 0) return -1;
    if (wedge == 0) return 0;
    return 1;
  endfunction

  // Update the store mirror, or cull a triangle and queue its three corners
  task automatic cull_and_emit(input logic cmd, input logic [SLOT_W-1:0] slot,
                               input logic [31:0] px, py, tu, tv, tw,
                               input logic [15:0] ca, cb, cc);
    int      idx [3];
    int      limit_eff;
    int      s;
    corner_t c;
    if (cmd == CMD_WRITE_VTX) begin
      vtx_x[slot] = px;
      vtx_y[slot] = py;
      vtx_u[slot] = tu;
      vtx_v[slot] = tv;
      vtx_w[slot] = tw;
      if (!vtx_written[slot]) written_slots.insert(written_slots.size(), int'(slot));
      vtx_written[slot] = 1'b1;
      return;
    end
    limit_eff = (vtx_limit > VERTEX_DEPTH) ? VERTEX_DEPTH : int'(vtx_limit);
    idx[0] = $signed(ca);
    idx[1] = $signed(cb);
    idx[2] = $signed(cc);
    foreach (idx[k]) if (idx[k] < 0 || idx[k] >= limit_eff) return;
    if (cull_dir != DIR_KEEP_ALL) begin
      s = winding_sign(idx[0], idx[1], idx[2]);
      if (cull_dir[1]) s = -s;
      if (strict_mode ? (s <= 0) : (s < 0)) return;
    end
    if (kept_count != KEPT_MAX) kept_count++;
    for (int k = 0; k < 3; k++) begin
      c.x    = vtx_x[idx[k]];
      c.y    = vtx_y[idx[k]];
      c.u    = (tex_parts >= TEX_UV) ? vtx_u[idx[k]] : '0;
      c.v    = (tex_parts >= TEX_UV) ? vtx_v[idx[k]] : '0;
      c.w    = (tex_parts == TEX_PARTS_UVW) ? vtx_w[idx[k]] : '0;
      c.num  = 2'(k);
      c.last = (2'(k) == CORNER_LAST);
      c.kept = kept_count;
      pending_corners.insert(pending_corners.size(), c);
    end
  endtask

  // Offer one item after an optional idle gap; return at the edge it transfers
  task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [31:0] px, py, tu, tv, tw,
                           input logic [15:0] ca, cb, cc);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_TDATA_W'({cc, cb, ca, tw, tv, tu, py, px, slot});
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    cull_and_emit(cmd, slot, px, py, tu, tv, tw, ca, cb, cc);
  endtask

  task automatic write_vertex(input int slot, input logic [31:0] px, py, tu, tv, tw);
    send_item(CMD_WRITE_VTX, SLOT_W'(slot), px, py, tu, tv, tw,
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_triangle(input logic [15:0] ca, cb, cc);
    send_item(CMD_TRIANGLE, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
              $urandom, ca, cb, cc);
  endtask

  // Hold the input idle until every corner is back and the block has settled
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers, one per cycle, with the block idle
  task automatic apply_settings(input logic [1:0] dir, input logic [1:0] parts,
                                input logic [10:0] limit, input logic strict);
    cfg_idx_t  idx_list  [4];
    cfg_data_t data_list [4];
    wait_drain();
    idx_list  = '{CFG_CULL_DIR, CFG_TEX_PARTS, CFG_VTX_LIMIT, CFG_STRICT};
    data_list = '{cfg_data_t'(dir), cfg_data_t'(parts), cfg_data_t'(limit),
                  cfg_data_t'(strict)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= data_list[i];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    cull_dir    = dir;
    tex_parts   = parts;
    vtx_limit   = limit;
    strict_mode = strict;
  endtask

  function automatic logic [31:0] rand_coord();
    int s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_M_ONE;
          default: return '0;
        endcase
      end
      1, 2, 3, 4: begin
        // small grid values make zero-area and near-degenerate triangles likely
        s = int'($urandom_range(16)) - 8;
        return 32'(s * 65536);
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly written slots; sometimes an index the bound check must reject
  function automatic logic [15:0] pick_corner();
    int limit_eff;
    limit_eff = (vtx_limit > VERTEX_DEPTH) ? VERTEX_DEPTH : int'(vtx_limit);
    if ($urandom_range(99) < 10 || written_slots.size() == 0) begin
      case ($urandom_range(3))
        0: return 16'(-1 - int'($urandom_range(32767)));
        1: return 16'(limit_eff + int'($urandom_range(15)));
        2: return 16'($urandom_range(32767, 1024));
        default: return 16'h7FFF;
      endcase
    end
    return 16'(written_slots[$urandom_range(written_slots.size() - 1)]);
  endfunction

  task automatic random_settings();
    logic [10:0] limit;
    case ($urandom_range(5))
      0: limit = 11'($urandom_range(2047));
      1: limit = 11'd2047;
      2: limit = 11'd1024;
      3: limit = '0;
      default: limit = 11'($urandom_range(32, 20));
    endcase
    apply_settings(2'($urandom), 2'($urandom), limit, 1'($urandom));
  endtask

  // Receive corners, stall at random or for a requested hold-off, and check
  always @(posedge clk_i) begin
    corner_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_corners.size() == 0) begin
        report_mismatch($sformatf("unexpected corner %h", m_axis_tdata));
      end else begin
        want = pending_corners.pop_front();
        compare_field("out_x", m_axis_tdata[31:0], want.x);
        compare_field("out_y", m_axis_tdata[63:32], want.y);
        compare_field("out_u", m_axis_tdata[95:64], want.u);
        compare_field("out_v", m_axis_tdata[127:96], want.v);
        compare_field("out_w", m_axis_tdata[159:128], want.w);
        compare_field("kept_total", 32'(m_axis_tdata[175:160]), 32'(want.kept));
        compare_field("corner_number", 32'(m_axis_tuser), 32'(want.num));
        compare_field("last_corner", 32'(m_axis_tlast), 32'(want.last));
      end
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Reset settings leave the vertex bound at zero, so every triangle drops
  task automatic test_reset_defaults();
    write_vertex(0, Q_ONE, Q_ONE, '0, '0, '0);
    send_triangle(16'd0, 16'd0, 16'd0);
  endtask

  task automatic test_directed_cases();
    apply_settings(DIR_KEEP_ALL, TEX_PARTS_UVW, 11'd1024, 1'b0);
    write_vertex(0, '0, '0, 32'd1, 32'd2, 32'd3);
    write_vertex(1, Q_ONE, '0, 32'd4, 32'd5, 32'd6);
    write_vertex(2, '0, Q_ONE, 32'd7, 32'd8, 32'd9);
    write_vertex(3, Q_MAX, Q_MIN, Q_M_ONE, Q_MIN, Q_MAX);
    write_vertex(1023, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    write_vertex(4, 2 * Q_ONE, '0, Q_MIN, Q_M_ONE, '0);
    // keep all: valid triangles pass, bad indices drop
    send_triangle(16'd0, 16'd1, 16'd2);
    send_triangle(16'd3, 16'd1023, 16'd0);
    send_triangle(16'hFFFF, 16'd0, 16'd1);
    send_triangle(16'd0, 16'h8000, 16'd1);
    send_triangle(16'd0, 16'd1, 16'h7FFF);
    send_triangle(16'd0, 16'd1, 16'd1024);
    // positive winding survives; zero area kept when not strict
    apply_settings(DIR_POS, TEX_UV, 11'd1024, 1'b0);
    send_triangle(16'd0, 16'd1, 16'd2);
    send_triangle(16'd0, 16'd2, 16'd1);
    send_triangle(16'd0, 16'd1, 16'd4);
    send_triangle(16'd3, 16'd1023, 16'd0);
    // negative winding, strict, single texture part acts as none
    apply_settings(DIR_NEG, TEX_ONE, 11'd1024, 1'b1);
    send_triangle(16'd0, 16'd2, 16'd1);
    send_triangle(16'd0, 16'd1, 16'd2);
    send_triangle(16'd0, 16'd1, 16'd4);
    // direction -2 acts as -1; bound above the depth acts as the depth
    apply_settings(DIR_NEG_WIDE, TEX_NONE, 11'd2047, 1'b1);
    send_triangle(16'd0, 16'd2, 16'd1);
    send_triangle(16'd3, 16'd1023, 16'd1);
    // keep all ignores strict mode; index equal to the bound drops
    apply_settings(DIR_KEEP_ALL, TEX_PARTS_UVW, 11'd3, 1'b1);
    send_triangle(16'd0, 16'd1, 16'd4);
    send_triangle(16'd0, 16'd1, 16'd1);
    send_triangle(16'd0, 16'd1, 16'd3);
  endtask

  // Long receiver hold-off while the sender keeps offering triangles
  task automatic test_output_backpressure();
    apply_settings(DIR_KEEP_ALL, TEX_PARTS_UVW, 11'd1024, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (16) send_triangle(pick_corner(), pick_corner(), pick_corner());
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 85, 0, 15};
    int stall_mix [4] = '{0, 0, 85, 15};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      for (int chunk = 0; chunk < 3; chunk++) begin
        random_settings();
        for (int n = 0; n < 37; n++) begin
          if ($urandom_range(99) < 30 || written_slots.size() == 0) begin
            write_vertex(($urandom_range(99) < 85) ? $urandom_range(31) : $urandom_range(1023),
                         rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
          end else begin
            send_triangle(pick_corner(), pick_corner(), pick_corner());
          end
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic();
    wait_drain();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest passing run
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
rtl/itbc_pkg.sv
rtl/itbc_ram.sv
rtl/indexed_triangle_backface_cull.sv
test/tb.sv
